### rtl/mbrtu_pkg.sv
// shared constants for the modbus rtu read holding registers slave
package mbrtu_pkg;
  localparam int FRAME_BYTES_MAX_DEF = 256;
  localparam int REG_DEPTH_DEF       = 64;
  localparam int MAX_QUANTITY_DEF    = 16;

  localparam logic [15:0] CRC_START = 16'hFFFF;
  localparam logic [15:0] CRC_POLY  = 16'hA001;
  localparam logic [7:0]  EXC_FLAG  = 8'h80;

  localparam logic [7:0] FUNC_READ_HOLDING    = 8'd3;
  localparam logic [7:0] EXC_ILLEGAL_FUNCTION = 8'd1;
  localparam logic [7:0] EXC_ILLEGAL_ADDRESS  = 8'd2;
  localparam logic [7:0] EXC_ILLEGAL_VALUE    = 8'd3;

  localparam logic [1:0] REG_SLAVE_ADDRESS = 2'd0;

  localparam logic [7:0] SLAVE_ADDRESS_RESET = 8'd1;
endpackage

### rtl/mbrtu_if.sv
// handshake channels for received items and reply bytes
interface mbrtu_rx_if;
  logic       valid;
  logic       ready;
  logic       mode;
  logic [7:0] rx_byte;
  modport source (output valid, output mode, output rx_byte, input ready);
  modport sink (input valid, input mode, input rx_byte, output ready);
endinterface

interface mbrtu_tx_if;
  logic       valid;
  logic       ready;
  logic [7:0] tx_byte;
  logic       last_byte;
  modport source (output valid, output tx_byte, output last_byte, input ready);
  modport sink (input valid, input tx_byte, input last_byte, output ready);
endinterface

### rtl/modbus_rtu_slave_read_holding.sv
// modbus rtu slave answering read holding registers
// a received byte is accepted in idle and then run through the bit-serial crc shifter
// end of frame is checked in idle; each reply byte is then loaded and shifted through the crc,
// the two crc bytes are only loaded, and any wait on the reply channel stalls the load
// the holding store is constant (entry k is k plus one) and needs no storage
// synchronous active-high reset: slave address 1, empty frame, crc 0xffff
module modbus_rtu_slave_read_holding #(
  parameter int FRAME_BYTES_MAX = mbrtu_pkg::FRAME_BYTES_MAX_DEF,
  parameter int REG_DEPTH       = mbrtu_pkg::REG_DEPTH_DEF,
  parameter int MAX_QUANTITY    = mbrtu_pkg::MAX_QUANTITY_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  mbrtu_rx_if.sink    rx,
  mbrtu_tx_if.source  tx
);
  import mbrtu_pkg::*;

  localparam int CNT_W = $clog2(FRAME_BYTES_MAX + 1);
  localparam int DL_W  = $clog2(2 * MAX_QUANTITY + 1);

  typedef enum logic [2:0] {S_IDLE, S_RXCRC, S_TXLOAD, S_TXCRC} state_t;
  typedef enum logic [2:0] {Q_ADDR, Q_FUNC, Q_CNT, Q_DATA, Q_CRCL, Q_CRCH} seq_t;

  state_t            state;
  seq_t              seq;
  logic [7:0]        slave_address;
  logic [CNT_W-1:0]  frame_count;
  logic [15:0]       crc;
  logic [2:0]        bit_cnt;
  logic [7:0]        hdr [6];
  logic [7:0]        reply_func;
  logic [7:0]        reply_third;
  logic              reply_data;
  logic [DL_W-1:0]   data_left;
  logic [15:0]       word;
  logic              hi_next;
  logic              out_valid;
  logic [7:0]        out_byte;
  logic              out_last;

  logic [15:0] crc_shift;
  logic [15:0] req_start;
  logic [15:0] req_qty;
  logic [16:0] req_end;
  logic        frame_ok;
  logic        out_free;
  logic [7:0]  load_byte;

  assign pready = 1'b1;
  assign prdata = (paddr == REG_SLAVE_ADDRESS) ? {24'd0, slave_address} : 32'd0;

  assign rx.ready     = (state == S_IDLE);
  assign tx.valid     = out_valid;
  assign tx.tx_byte   = out_byte;
  assign tx.last_byte = out_last;

  assign crc_shift = crc[0] ? ((crc >> 1) ^ CRC_POLY) : (crc >> 1);
  assign req_start = {hdr[2], hdr[3]};
  assign req_qty   = {hdr[4], hdr[5]};
  assign req_end   = {1'b0, req_start} + {1'b0, req_qty};
  assign frame_ok  = (frame_count >= CNT_W'(4)) && (hdr[0] != 8'd0) &&
                     (hdr[0] == slave_address) && (crc == 16'd0);
  assign out_free  = !out_valid || tx.ready;

  always_comb begin
    case (seq)
      Q_ADDR:  load_byte = slave_address;
      Q_FUNC:  load_byte = reply_func;
      Q_CNT:   load_byte = reply_third;
      Q_DATA:  load_byte = hi_next ? word[15:8] : word[7:0];
      Q_CRCL:  load_byte = crc[7:0];
      default: load_byte = crc[15:8];
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      seq           <= Q_ADDR;
      slave_address <= SLAVE_ADDRESS_RESET;
      frame_count   <= '0;
      crc           <= CRC_START;
      bit_cnt       <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (psel && penable && pwrite && paddr == REG_SLAVE_ADDRESS) begin
        slave_address <= pwdata[7:0];
      end
      // the load state refills the output register itself
      if (out_valid && tx.ready && state != S_TXLOAD) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (rx.valid) begin
            if (rx.mode) begin
              frame_count <= '0;
              crc         <= CRC_START;
              seq         <= Q_ADDR;
              hi_next     <= 1'b1;
              word        <= req_start + 16'd1;
              data_left   <= DL_W'({req_qty, 1'b0});
              if (frame_ok) begin
                if (hdr[1] != FUNC_READ_HOLDING) begin
                  reply_func  <= hdr[1] | EXC_FLAG;
                  reply_third <= EXC_ILLEGAL_FUNCTION;
                  reply_data  <= 1'b0;
                  state       <= S_TXLOAD;
                end else if (frame_count >= CNT_W'(8)) begin
                  state <= S_TXLOAD;
                  if (req_qty == 16'd0) begin
                    reply_func  <= hdr[1] | EXC_FLAG;
                    reply_third <= EXC_ILLEGAL_VALUE;
                    reply_data  <= 1'b0;
                  end else if (req_qty > 16'(MAX_QUANTITY) ||
                               req_end > 17'(REG_DEPTH)) begin
                    reply_func  <= hdr[1] | EXC_FLAG;
                    reply_third <= EXC_ILLEGAL_ADDRESS;
                    reply_data  <= 1'b0;
                  end else begin
                    reply_func  <= hdr[1];
                    reply_third <= {req_qty[6:0], 1'b0};
                    reply_data  <= 1'b1;
                  end
                end
              end
            end else if (frame_count < CNT_W'(FRAME_BYTES_MAX)) begin
              if (frame_count < CNT_W'(6)) begin
                hdr[frame_count[2:0]] <= rx.rx_byte;
              end
              crc         <= crc ^ {8'd0, rx.rx_byte};
              frame_count <= frame_count + CNT_W'(1);
              bit_cnt     <= '0;
              state       <= S_RXCRC;
            end
          end
        end
        S_RXCRC, S_TXCRC: begin
          crc     <= crc_shift;
          bit_cnt <= bit_cnt + 3'd1;
          if (bit_cnt == 3'd7) begin
            state <= (state == S_RXCRC) ? S_IDLE : S_TXLOAD;
          end
        end
        S_TXLOAD: begin
          if (out_free) begin
            out_valid <= 1'b1;
            out_byte  <= load_byte;
            out_last  <= (seq == Q_CRCH);
            bit_cnt   <= '0;
            if (seq != Q_CRCL && seq != Q_CRCH) begin
              crc   <= crc ^ {8'd0, load_byte};
              state <= S_TXCRC;
            end
            case (seq)
              Q_ADDR: seq <= Q_FUNC;
              Q_FUNC: seq <= Q_CNT;
              Q_CNT:  seq <= reply_data ? Q_DATA : Q_CRCL;
              Q_DATA: begin
                hi_next   <= !hi_next;
                data_left <= data_left - DL_W'(1);
                if (!hi_next) begin
                  word <= word + 16'd1;
                end
                if (data_left == DL_W'(1)) begin
                  seq <= Q_CRCL;
                end
              end
              Q_CRCL: seq <= Q_CRCH;
              default: begin
                seq   <= Q_ADDR;
                state <= S_IDLE;
                crc   <= CRC_START;
              end
            endcase
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
